// ----- sv/ostrt_pkg.sv -----
// Package: codes, widths and shared types of the ordered slot reorder tracker.
package ostrt_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SEQ_W          = 64;
    localparam int SLOT_W         = 8;
    localparam int OP_W           = 3;
    localparam int STATUS_W       = 3;

    localparam logic [OP_W-1:0] OP_ACQUIRE  = 3'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 3'd1;
    localparam logic [OP_W-1:0] OP_FAIL     = 3'd2;
    localparam logic [OP_W-1:0] OP_PUBLISH  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FAILED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INDEX      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STALE      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_STATE      = 3'd6;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd7;

    typedef enum logic [1:0] {
        PH_FREE      = 2'd0,
        PH_SUBMITTED = 2'd1,
        PH_COMPLETED = 2'd2,
        PH_FAILED    = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [SEQ_W-1:0]   tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        phase_t             phase;
        logic [SEQ_W-1:0]   tag;
        logic               tag_hit;
        logic               is_free;
        logic               is_submitted;
        logic               is_completed;
    } match_t;

endpackage

// ----- sv/ordered_slot_reorder_tracker_unit.sv -----
// Top level: sequencer, slot table and result register of the ordered slot reorder tracker.
// Sequence: complete, fail and publish go through PRE, READ, TEST and DONE to the result word;
// acquire and query scan the slot table one slot per READ/TEST pass, up to SLOT_COUNT slots.
// Early answers (failed, out of order, full, bad index, bad opcode) go from PRE straight to DONE.
// Throughput: one word at a time; the slot table RAM read port is visited once per slot step.
// Reset: all slots free via per-slot valid bits cleared at once, counters zero, no sweep.
module ordered_slot_reorder_tracker_unit #(
    parameter int SLOT_COUNT = ostrt_pkg::SLOT_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] lease_slot, [71:8] lease_sequence
    input  logic [71:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [10:3] granted_slot, [74:11] granted_sequence,
    // [75] table_empty, [76] failure_seen, [79:77] zero
    output logic [79:0] m_tdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int SEQ_W = ostrt_pkg::SEQ_W;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PRE,
        FSM_READ,
        FSM_TEST,
        FSM_DONE
    } fsm_t;

    fsm_t                          state_reg, state_next;
    logic [ostrt_pkg::OP_W-1:0]    op_reg, op_next;
    logic [7:0]                    slot_reg, slot_next;
    logic [SEQ_W-1:0]              seq_reg, seq_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [SEQ_W-1:0]              acq_cnt_reg, acq_cnt_next;
    logic [SEQ_W-1:0]              pub_cnt_reg, pub_cnt_next;
    logic [SEQ_W-1:0]              low_fail_reg, low_fail_next;
    logic                          fail_valid_reg, fail_valid_next;
    logic [CNT_W-1:0]              busy_reg, busy_next;
    logic [SLOT_COUNT-1:0]         valid_reg, valid_next;
    logic [2:0]                    res_status_reg, res_status_next;
    logic [7:0]                    res_slot_reg, res_slot_next;
    logic [SEQ_W-1:0]              res_seq_reg, res_seq_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [79:0]                   m_tdata_reg, m_tdata_next;

    logic                          ram_we;
    ostrt_pkg::entry_t             ram_wdata;
    logic [ostrt_pkg::ENTRY_W-1:0] ram_rdata;
    ostrt_pkg::match_t             mt;
    logic [SEQ_W-1:0]              key;
    logic                          bad_index;
    logic                          last_slot;
    logic                          lease_ok;
    logic [2:0]                    lease_status;

    ostrt_ram #(
        .WIDTH (ostrt_pkg::ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign key = (op_reg == ostrt_pkg::OP_QUERY) ? pub_cnt_reg : seq_reg;

    ostrt_match u_match (
        .entry_valid (valid_reg[idx_reg]),
        .entry       (ram_rdata),
        .key         (key),
        .result      (mt)
    );

    assign bad_index = ({1'b0, slot_reg} >= 9'(SLOT_COUNT));
    assign last_slot = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    always_comb begin
        lease_status = ostrt_pkg::ST_OK;
        case (op_reg)
            ostrt_pkg::OP_COMPLETE: begin
                if (!mt.tag_hit) begin
                    lease_status = ostrt_pkg::ST_STALE;
                end else if (!mt.is_submitted) begin
                    lease_status = ostrt_pkg::ST_STATE;
                end
            end
            ostrt_pkg::OP_FAIL: begin
                if (!mt.tag_hit) begin
                    lease_status = ostrt_pkg::ST_STALE;
                end else if (!(mt.is_submitted || mt.is_completed)) begin
                    lease_status = ostrt_pkg::ST_STATE;
                end
            end
            ostrt_pkg::OP_PUBLISH: begin
                if (!mt.tag_hit) begin
                    lease_status = ostrt_pkg::ST_STALE;
                end else if (!mt.is_completed) begin
                    lease_status = ostrt_pkg::ST_STATE;
                end
            end
            default: begin
                lease_status = ostrt_pkg::ST_STATE;
            end
        endcase
    end

    assign lease_ok = (lease_status == ostrt_pkg::ST_OK);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        seq_next        = seq_reg;
        idx_next        = idx_reg;
        acq_cnt_next    = acq_cnt_reg;
        pub_cnt_next    = pub_cnt_reg;
        low_fail_next   = low_fail_reg;
        fail_valid_next = fail_valid_reg;
        busy_next       = busy_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_seq_next    = res_seq_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_wdata.phase = ostrt_pkg::PH_FREE;
        ram_wdata.tag   = seq_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    slot_next  = s_tdata[7:0];
                    seq_next   = s_tdata[71:8];
                    state_next = FSM_PRE;
                end
            end
            FSM_PRE: begin
                res_status_next = ostrt_pkg::ST_STATE;
                res_slot_next   = '0;
                res_seq_next    = '0;
                state_next      = FSM_DONE;
                idx_next        = '0;
                case (op_reg)
                    ostrt_pkg::OP_ACQUIRE: begin
                        if (fail_valid_reg) begin
                            res_status_next = ostrt_pkg::ST_FAILED;
                        end else if (seq_reg != acq_cnt_reg) begin
                            res_status_next = ostrt_pkg::ST_ORDER;
                        end else if (busy_reg == CNT_W'(SLOT_COUNT)) begin
                            res_status_next = ostrt_pkg::ST_FULL;
                        end else begin
                            state_next = FSM_READ;
                        end
                    end
                    ostrt_pkg::OP_COMPLETE, ostrt_pkg::OP_FAIL: begin
                        if (bad_index) begin
                            res_status_next = ostrt_pkg::ST_INDEX;
                        end else begin
                            idx_next   = slot_reg[IDX_W-1:0];
                            state_next = FSM_READ;
                        end
                    end
                    ostrt_pkg::OP_PUBLISH: begin
                        if (seq_reg != pub_cnt_reg) begin
                            res_status_next = ostrt_pkg::ST_ORDER;
                        end else if (bad_index) begin
                            res_status_next = ostrt_pkg::ST_INDEX;
                        end else begin
                            idx_next   = slot_reg[IDX_W-1:0];
                            state_next = FSM_READ;
                        end
                    end
                    ostrt_pkg::OP_QUERY: begin
                        if (fail_valid_reg && (pub_cnt_reg >= low_fail_reg)) begin
                            res_status_next = ostrt_pkg::ST_FAILED;
                        end else begin
                            state_next = FSM_READ;
                        end
                    end
                    default: begin
                        res_status_next = ostrt_pkg::ST_STATE;
                    end
                endcase
            end
            FSM_READ: begin
                state_next = FSM_TEST;
            end
            FSM_TEST: begin
                state_next = FSM_DONE;
                case (op_reg)
                    ostrt_pkg::OP_ACQUIRE: begin
                        if (mt.is_free) begin
                            ram_we               = 1'b1;
                            ram_wdata.phase      = ostrt_pkg::PH_SUBMITTED;
                            valid_next[idx_reg]  = 1'b1;
                            acq_cnt_next         = acq_cnt_reg + 1'b1;
                            busy_next            = busy_reg + 1'b1;
                            res_status_next      = ostrt_pkg::ST_OK;
                            res_slot_next        = 8'(idx_reg);
                            res_seq_next         = seq_reg;
                        end else if (last_slot) begin
                            res_status_next = ostrt_pkg::ST_FULL;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = FSM_READ;
                        end
                    end
                    ostrt_pkg::OP_QUERY: begin
                        if (mt.tag_hit && mt.is_completed) begin
                            res_status_next = ostrt_pkg::ST_OK;
                            res_slot_next   = 8'(idx_reg);
                            res_seq_next    = mt.tag;
                        end else if (last_slot) begin
                            res_status_next = ostrt_pkg::ST_INCOMPLETE;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = FSM_READ;
                        end
                    end
                    default: begin
                        res_status_next = lease_status;
                        if (lease_ok) begin
                            ram_we              = 1'b1;
                            valid_next[idx_reg] = 1'b1;
                            case (op_reg)
                                ostrt_pkg::OP_COMPLETE: begin
                                    ram_wdata.phase = ostrt_pkg::PH_COMPLETED;
                                end
                                ostrt_pkg::OP_FAIL: begin
                                    ram_wdata.phase = ostrt_pkg::PH_FAILED;
                                    if (!fail_valid_reg || (seq_reg < low_fail_reg)) begin
                                        low_fail_next   = seq_reg;
                                        fail_valid_next = 1'b1;
                                    end
                                end
                                default: begin
                                    ram_wdata.phase = ostrt_pkg::PH_FREE;
                                    pub_cnt_next    = pub_cnt_reg + 1'b1;
                                    busy_next       = busy_reg - 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
            end
            FSM_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, fail_valid_reg, (busy_reg == '0),
                                     res_seq_reg, res_slot_reg, res_status_reg};
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_IDLE;
            acq_cnt_reg    <= '0;
            pub_cnt_reg    <= '0;
            low_fail_reg   <= '1;
            fail_valid_reg <= 1'b0;
            busy_reg       <= '0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acq_cnt_reg    <= acq_cnt_next;
            pub_cnt_reg    <= pub_cnt_next;
            low_fail_reg   <= low_fail_next;
            fail_valid_reg <= fail_valid_next;
            busy_reg       <= busy_next;
            valid_reg      <= valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        seq_reg        <= seq_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_seq_reg    <= res_seq_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == FSM_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_busy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg <= CNT_W'(SLOT_COUNT))
        else $error("busy slot count exceeds table size");

    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fail_valid_reg |=> fail_valid_reg)
        else $error("failure record cleared");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] != ostrt_pkg::ST_OK)) |-> (m_tdata[74:3] == '0))
        else $error("granted fields set on a non-ok result");

    a_publish_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_TEST && op_reg == ostrt_pkg::OP_PUBLISH && lease_ok)
        |=> (pub_cnt_reg == $past(pub_cnt_reg) + 1'b1))
        else $error("publish counter did not advance");

endmodule

// ----- sv/ostrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ostrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ostrt_match.sv -----
// Shared slot evaluator: resolves an entry's phase and tag and compares the tag to a key.
module ostrt_match (
    input  logic                           entry_valid,
    input  ostrt_pkg::entry_t              entry,
    input  logic [ostrt_pkg::SEQ_W-1:0]    key,
    output ostrt_pkg::match_t              result
);

    ostrt_pkg::phase_t                phase;
    logic [ostrt_pkg::SEQ_W-1:0]      tag;

    // never-written entries read as free with a zero tag
    assign phase = entry_valid ? entry.phase : ostrt_pkg::PH_FREE;
    assign tag   = entry_valid ? entry.tag : '0;

    always_comb begin
        result.phase        = phase;
        result.tag          = tag;
        result.tag_hit      = (tag == key);
        result.is_free      = (phase == ostrt_pkg::PH_FREE);
        result.is_submitted = (phase == ostrt_pkg::PH_SUBMITTED);
        result.is_completed = (phase == ostrt_pkg::PH_COMPLETED);
    end

endmodule

// ----- dv/tb_ordered_slot_reorder_tracker_unit.sv -----
// Testbench: stream-driven self-checking test of the ordered slot reorder tracker.
module tb_ordered_slot_reorder_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_N       = ostrt_pkg::SLOT_COUNT_DEF;
    localparam int OP_W         = ostrt_pkg::OP_W;
    localparam int SLOT_W       = ostrt_pkg::SLOT_W;
    localparam int SEQ_W        = ostrt_pkg::SEQ_W;
    localparam int STATUS_W     = ostrt_pkg::STATUS_W;
    localparam int RAND_ITEMS   = 1150;
    localparam int TAIL_ITEMS   = 80;
    localparam int HOLD_LEN     = 250;
    localparam int HOLD_EVERY   = 600;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 3 + 2 * SLOT_N + 20;

    localparam logic [OP_W-1:0] OP_CODE_MAX = '1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq;
    } lease_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SEQ_W-1:0]    seq;
        logic                empty;
        logic                failed;
    } tracker_rsp_t;

    typedef struct packed {
        ostrt_pkg::phase_t [SLOT_N-1:0] ph;
        logic [SLOT_N-1:0][SEQ_W-1:0]   tag;
        logic [SEQ_W-1:0]               acq_cnt;
        logic [SEQ_W-1:0]               pub_cnt;
        logic [SEQ_W-1:0]               low_fail;
        logic                           fail_rec;
    } tracker_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    tracker_t     gen_st;
    tracker_t     chk_st;
    lease_req_t   stim_q[$];
    tracker_rsp_t rsp_expect_q[$];

    int words_in      = 0;
    int words_offered = 0;
    int total_words   = 0;
    int results_out   = 0;
    int err_cnt       = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int hold_left     = 0;
    int next_hold_at  = 300;
    int rx_tick       = 0;
    int idle_cycles   = 0;
    int empty_seen    = 0;
    int st_seen[8]    = '{default: 0};

    ordered_slot_reorder_tracker_unit #(.SLOT_COUNT(SLOT_N)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic tracker_t tracker_reset_state();
        tracker_t st;
        st = '0;
        st.low_fail = '1;
        return st;
    endfunction

    function automatic logic [STATUS_W-1:0] lease_status(input tracker_t st, input int idx,
                                                         input logic [SEQ_W-1:0] seq,
                                                         input ostrt_pkg::phase_t want);
        if (idx >= SLOT_N) return ostrt_pkg::ST_INDEX;
        if (st.tag[idx] != seq) return ostrt_pkg::ST_STALE;
        if (st.ph[idx] != want) return ostrt_pkg::ST_STATE;
        return ostrt_pkg::ST_OK;
    endfunction

    function automatic void tracker_step(inout tracker_t st, input lease_req_t rq,
                                         output tracker_rsp_t rs);
        int idx;
        int i;
        bit found;
        idx = int'(rq.slot);
        found = 1'b0;
        rs = '0;
        rs.status = ostrt_pkg::ST_STATE;
        case (rq.op)
            ostrt_pkg::OP_ACQUIRE: begin
                if (st.fail_rec) begin
                    rs.status = ostrt_pkg::ST_FAILED;
                end else if (rq.seq != st.acq_cnt) begin
                    rs.status = ostrt_pkg::ST_ORDER;
                end else begin
                    rs.status = ostrt_pkg::ST_FULL;
                    for (i = 0; i < SLOT_N; i++) begin
                        if (!found && st.ph[i] == ostrt_pkg::PH_FREE) begin
                            found = 1'b1;
                            st.ph[i] = ostrt_pkg::PH_SUBMITTED;
                            st.tag[i] = rq.seq;
                            st.acq_cnt = st.acq_cnt + 1;
                            rs.slot = SLOT_W'(i);
                            rs.seq = rq.seq;
                            rs.status = ostrt_pkg::ST_OK;
                        end
                    end
                end
            end
            ostrt_pkg::OP_COMPLETE: begin
                rs.status = lease_status(st, idx, rq.seq, ostrt_pkg::PH_SUBMITTED);
                if (rs.status == ostrt_pkg::ST_OK) st.ph[idx] = ostrt_pkg::PH_COMPLETED;
            end
            ostrt_pkg::OP_FAIL: begin
                rs.status = lease_status(st, idx, rq.seq, ostrt_pkg::PH_SUBMITTED);
                if (rs.status != ostrt_pkg::ST_OK)
                    rs.status = lease_status(st, idx, rq.seq, ostrt_pkg::PH_COMPLETED);
                if (rs.status == ostrt_pkg::ST_OK) begin
                    st.ph[idx] = ostrt_pkg::PH_FAILED;
                    if (!st.fail_rec || rq.seq < st.low_fail) begin
                        st.low_fail = rq.seq;
                        st.fail_rec = 1'b1;
                    end
                end
            end
            ostrt_pkg::OP_PUBLISH: begin
                if (rq.seq != st.pub_cnt) begin
                    rs.status = ostrt_pkg::ST_ORDER;
                end else begin
                    rs.status = lease_status(st, idx, rq.seq, ostrt_pkg::PH_COMPLETED);
                    if (rs.status == ostrt_pkg::ST_OK) begin
                        st.ph[idx] = ostrt_pkg::PH_FREE;
                        st.pub_cnt = st.pub_cnt + 1;
                    end
                end
            end
            ostrt_pkg::OP_QUERY: begin
                if (st.fail_rec && st.pub_cnt >= st.low_fail) begin
                    rs.status = ostrt_pkg::ST_FAILED;
                end else begin
                    rs.status = ostrt_pkg::ST_INCOMPLETE;
                    for (i = 0; i < SLOT_N; i++) begin
                        if (!found && st.tag[i] == st.pub_cnt &&
                            st.ph[i] == ostrt_pkg::PH_COMPLETED) begin
                            found = 1'b1;
                            rs.slot = SLOT_W'(i);
                            rs.seq = st.tag[i];
                            rs.status = ostrt_pkg::ST_OK;
                        end
                    end
                end
            end
            default: ;
        endcase
        rs.empty = 1'b1;
        for (i = 0; i < SLOT_N; i++) begin
            if (st.ph[i] != ostrt_pkg::PH_FREE) rs.empty = 1'b0;
        end
        rs.failed = st.fail_rec;
    endfunction

    // stimulus side: keeps its own tracker copy so leases can be aimed at live slots
    function automatic void push_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                     input logic [SEQ_W-1:0] seq);
        lease_req_t   rq;
        tracker_rsp_t rs;
        rq.op = op;
        rq.slot = slot;
        rq.seq = seq;
        tracker_step(gen_st, rq, rs);
        stim_q.push_back(rq);
    endfunction

    function automatic logic [SEQ_W-1:0] rand_seq();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SLOT_W-1:0] any_slot();
        return SLOT_W'($urandom_range(0, 255));
    endfunction

    function automatic int pick_slot(input bit want_sub, input bit want_cmp, input bit want_free);
        int hits[$];
        int i;
        for (i = 0; i < SLOT_N; i++) begin
            if ((want_sub && gen_st.ph[i] == ostrt_pkg::PH_SUBMITTED) ||
                (want_cmp && gen_st.ph[i] == ostrt_pkg::PH_COMPLETED) ||
                (want_free && gen_st.ph[i] == ostrt_pkg::PH_FREE)) hits.push_back(i);
        end
        if (hits.size() == 0) return -1;
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // malformed lease; keep_clean aims the case that reuses a slot's own tag only at free slots
    function automatic void gen_lease_noise(input logic [OP_W-1:0] op, input bit keep_clean);
        int idx;
        case ($urandom_range(0, 2))
            0: push_req(op, SLOT_W'($urandom_range(SLOT_N, 255)), rand_seq());
            1: push_req(op, SLOT_W'($urandom_range(0, SLOT_N - 1)), rand_seq());
            default: begin
                idx = keep_clean ? pick_slot(1'b0, 1'b0, 1'b1) : $urandom_range(0, SLOT_N - 1);
                if (idx < 0) push_req(op, any_slot(), rand_seq());
                else push_req(op, SLOT_W'(idx), gen_st.tag[idx]);
            end
        endcase
    endfunction

    function automatic void gen_acquire(input bit noisy);
        logic [SEQ_W-1:0] seq;
        seq = gen_st.acq_cnt;
        if (noisy) begin
            case ($urandom_range(0, 2))
                0: seq = gen_st.acq_cnt + SEQ_W'($urandom_range(1, 2));
                1: seq = gen_st.acq_cnt - 1;
                default: seq = rand_seq();
            endcase
        end
        push_req(ostrt_pkg::OP_ACQUIRE, any_slot(), seq);
    endfunction

    function automatic void gen_complete(input bit noisy);
        int idx;
        idx = pick_slot(1'b1, 1'b0, 1'b0);
        if (noisy || idx < 0) gen_lease_noise(ostrt_pkg::OP_COMPLETE, 1'b0);
        else push_req(ostrt_pkg::OP_COMPLETE, SLOT_W'(idx), gen_st.tag[idx]);
    endfunction

    function automatic void gen_publish(input bit noisy);
        int idx;
        int i;
        idx = -1;
        for (i = 0; i < SLOT_N; i++) begin
            if (idx < 0 && gen_st.ph[i] != ostrt_pkg::PH_FREE &&
                gen_st.tag[i] == gen_st.pub_cnt) idx = i;
        end
        if (!noisy && idx >= 0) begin
            if (gen_st.ph[idx] == ostrt_pkg::PH_SUBMITTED && $urandom_range(0, 1) == 1)
                push_req(ostrt_pkg::OP_COMPLETE, SLOT_W'(idx), gen_st.tag[idx]);
            else
                push_req(ostrt_pkg::OP_PUBLISH, SLOT_W'(idx), gen_st.pub_cnt);
        end else begin
            case ($urandom_range(0, 2))
                0: push_req(ostrt_pkg::OP_PUBLISH, (idx < 0) ? any_slot() : SLOT_W'(idx),
                            gen_st.pub_cnt + SEQ_W'($urandom_range(1, 3)));
                1: push_req(ostrt_pkg::OP_PUBLISH, SLOT_W'($urandom_range(SLOT_N, 255)),
                            gen_st.pub_cnt);
                default: push_req(ostrt_pkg::OP_PUBLISH,
                                  SLOT_W'($urandom_range(0, SLOT_N - 1)), gen_st.pub_cnt);
            endcase
        end
    endfunction

    function automatic void gen_query();
        push_req(ostrt_pkg::OP_QUERY, any_slot(), rand_seq());
    endfunction

    function automatic void gen_fail_hit();
        int idx;
        idx = pick_slot(1'b1, 1'b1, 1'b0);
        if (idx < 0) gen_query();
        else push_req(ostrt_pkg::OP_FAIL, SLOT_W'(idx), gen_st.tag[idx]);
    endfunction

    function automatic void gen_undefined();
        push_req(OP_W'($urandom_range(int'(ostrt_pkg::OP_QUERY) + 1, int'(OP_CODE_MAX))),
                 any_slot(), rand_seq());
    endfunction

    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] want);
        err_cnt++;
        if (err_cnt <= 50)
            $display("[%0t] %s: got %0h, expected %0h (result %0d)", $time, what, got, want,
                     results_out);
    endtask

    initial begin : stimulus
        int  n;
        int  r;
        int  w_acq;
        int  i;
        bit  noisy;
        gen_st = tracker_reset_state();
        chk_st = tracker_reset_state();

        push_req(ostrt_pkg::OP_QUERY, '0, '0);
        push_req(ostrt_pkg::OP_COMPLETE, 8'd0, 64'd0);
        push_req(ostrt_pkg::OP_PUBLISH, 8'd0, 64'd1);
        push_req(ostrt_pkg::OP_PUBLISH, 8'hFF, 64'd0);
        push_req(ostrt_pkg::OP_ACQUIRE, 8'd0, 64'd5);
        push_req(ostrt_pkg::OP_ACQUIRE, 8'hFF, '1);
        for (i = 0; i <= SLOT_N; i++) push_req(ostrt_pkg::OP_ACQUIRE, 8'd0, SEQ_W'(i));
        push_req(ostrt_pkg::OP_COMPLETE, 8'd3, 64'd99);
        push_req(ostrt_pkg::OP_COMPLETE, 8'd200, 64'd3);
        push_req(ostrt_pkg::OP_COMPLETE, SLOT_W'(SLOT_N - 1), SEQ_W'(SLOT_N - 1));
        push_req(ostrt_pkg::OP_QUERY, 8'hFF, '1);
        push_req(ostrt_pkg::OP_COMPLETE, 8'd0, 64'd0);
        push_req(ostrt_pkg::OP_QUERY, 8'd0, '0);
        push_req(ostrt_pkg::OP_PUBLISH, SLOT_W'(SLOT_N - 1), 64'd0);
        push_req(ostrt_pkg::OP_PUBLISH, 8'd0, 64'd0);
        push_req(ostrt_pkg::OP_FAIL, 8'd0, 64'd0);
        push_req(ostrt_pkg::OP_FAIL, 8'hFF, '1);
        push_req(OP_CODE_MAX, 8'hFF, '1);

        // main mix: fill-heavy, drain-heavy and balanced stretches, failures always rejected
        n = 0;
        while (n < RAND_ITEMS) begin
            w_acq = ((n / 150) % 3 == 1) ? 45 : (((n / 150) % 3 == 2) ? 10 : 28);
            noisy = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < w_acq) begin
                gen_acquire(noisy);
                n++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 38) gen_complete(noisy);
                else if (r < 72) gen_publish(noisy);
                else if (r < 84) gen_query();
                else if (r < 96) gen_lease_noise(ostrt_pkg::OP_FAIL, 1'b1);
                else gen_undefined();
                if (r < 96) n++;
            end
        end

        // failure handling closes the run: once recorded, acquires stay blocked
        for (i = 0; i < 4; i++) gen_acquire(1'b0);
        for (i = 0; i < 2; i++) gen_complete(1'b0);
        for (i = 0; i < TAIL_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) gen_fail_hit();
            else if (r < 40) gen_complete(1'b0);
            else if (r < 65) gen_publish(1'b0);
            else if (r < 80) gen_query();
            else if (r < 95) gen_acquire(1'b0);
            else gen_lease_noise(ostrt_pkg::OP_FAIL, 1'b0);
        end
        total_words = stim_q.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (words_in < total_words || rsp_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d words in, %0d results checked, %0d with empty table, %s",
                 words_in, results_out, empty_seen,
                 chk_st.fail_rec ? "failure recorded" : "no failure recorded");
        $display({"status mix ok/failed/order/full/index/stale/state/incomplete: ",
                  "%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d"},
                 st_seen[ostrt_pkg::ST_OK], st_seen[ostrt_pkg::ST_FAILED],
                 st_seen[ostrt_pkg::ST_ORDER], st_seen[ostrt_pkg::ST_FULL],
                 st_seen[ostrt_pkg::ST_INDEX], st_seen[ostrt_pkg::ST_STALE],
                 st_seen[ostrt_pkg::ST_STATE], st_seen[ostrt_pkg::ST_INCOMPLETE]);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // sender: bursts of words with random gaps; gaps are skipped while the receiver holds off
    always @(negedge aclk) begin : drive
        lease_req_t nxt;
        if (aresetn && (!s_tvalid || words_in == words_offered)) begin
            if (gap_left > 0 && hold_left == 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (stim_q.size() != 0) begin
                nxt = stim_q.pop_front();
                s_tuser <= nxt.op;
                s_tdata <= {nxt.seq, nxt.slot};
                s_tvalid <= 1'b1;
                words_offered <= words_offered + 1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall density, plus long hold-offs to back the block up
    always @(negedge aclk) begin : receive
        int rx_mode;
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (words_in >= next_hold_at) begin
                hold_left <= HOLD_LEN;
                next_hold_at <= next_hold_at + HOLD_EVERY;
                m_tready <= 1'b0;
            end else begin
                rx_tick <= rx_tick + 1;
                rx_mode = (rx_tick / 97) % 4;
                m_tready <= (rx_mode == 0) || ($urandom_range(0, rx_mode) == 0);
            end
        end
    end

    always @(posedge aclk) begin : monitor
        lease_req_t   rq;
        tracker_rsp_t rs;
        tracker_rsp_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (rsp_expect_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", m_tdata[63:0], '0);
                end else begin
                    want = rsp_expect_q.pop_front();
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch("status", SEQ_W'(m_tdata[2:0]), SEQ_W'(want.status));
                    if (m_tdata[10:3] !== want.slot)
                        report_mismatch("granted_slot", SEQ_W'(m_tdata[10:3]),
                                        SEQ_W'(want.slot));
                    if (m_tdata[74:11] !== want.seq)
                        report_mismatch("granted_sequence", m_tdata[74:11], want.seq);
                    if (m_tdata[75] !== want.empty)
                        report_mismatch("table_empty", SEQ_W'(m_tdata[75]), SEQ_W'(want.empty));
                    if (m_tdata[76] !== want.failed)
                        report_mismatch("failure_seen", SEQ_W'(m_tdata[76]),
                                        SEQ_W'(want.failed));
                    if (m_tdata[79:77] !== '0)
                        report_mismatch("pad bits", SEQ_W'(m_tdata[79:77]), '0);
                end
                results_out <= results_out + 1;
            end
            if (s_tvalid && s_tready) begin
                rq.op = s_tuser;
                rq.slot = s_tdata[7:0];
                rq.seq = s_tdata[71:8];
                tracker_step(chk_st, rq, rs);
                rsp_expect_q.push_back(rs);
                st_seen[rs.status]++;
                if (rs.empty) empty_seen++;
                words_in <= words_in + 1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
